### hw/rtl/scanned_button_bank_filter_assert.svh
// Assertion helpers for the button bank filter.
`ifndef SCANNED_BUTTON_BANK_FILTER_ASSERT_SVH
`define SCANNED_BUTTON_BANK_FILTER_ASSERT_SVH

`ifndef SYNTHESIS

`define SBBF_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define SBBF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SBBF_ASSERT(lbl, clk, rst, prop, msg)

`define SBBF_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

### hw/rtl/sbbf_pkg.sv
`default_nettype none

package sbbf_pkg;

  localparam int unsigned NUM_SLOTS = 3;
  localparam int unsigned NUM_BANKS = 3;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_RESP  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [2:0] MARK_PRIMARY   = 3'b111;
  localparam logic [2:0] MARK_SECONDARY = 3'b110;

  localparam logic [3:0] PH_IDLE = 4'd0;
  localparam logic [3:0] PH_8    = 4'd8;
  localparam logic [3:0] PH_4    = 4'd4;
  localparam logic [3:0] PH_2    = 4'd2;
  localparam logic [3:0] PH_1    = 4'd1;

  typedef logic [NUM_BANKS-1:0][7:0] bank_row_t;

  typedef struct packed {
    bank_row_t  banks;
    logic       any_pressed;
    logic [3:0] phase_code;
    logic       accepted;
  } result_t;

  // Per-phase scatter of the five sample bits into the slot's banks; in PH_1 bit 1 is mapped only when sec is set.
  function automatic bank_row_t map_sample(bank_row_t row, logic [3:0] phase,
                                           logic [4:0] s, logic sec);
    bank_row_t r;
    r = row;
    case (phase)
      PH_8: begin
        r[0][3] = s[3];
        r[0][1] = s[4];
        r[0][2] = s[1];
        r[0][0] = s[2];
        r[2][2] = s[0];
      end
      PH_4: begin
        r[0][4] = s[2];
        r[0][6] = s[1];
        r[0][5] = s[4];
        r[0][7] = s[3];
        r[1][0] = s[0];
      end
      PH_2: begin
        r[1][3] = s[0];
        r[1][5] = s[3];
        r[1][4] = s[4];
        r[1][7] = s[1];
        r[1][6] = s[2];
      end
      PH_1: begin
        r[2][5] = s[0];
        r[2][1] = s[3];
        r[1][2] = s[4];
        r[1][1] = s[2];
        if (sec) begin
          r[2][3] = s[1];
        end
      end
      default: begin
        r = row;
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/scanned_button_bank_filter.sv
// Button scan response filter.
// Input channel (in_valid/in_ready): one beat per item, op selects start of the
// next scan phase, a scan response, or a clear. Output channel (out_valid/out_ready):
// exactly one result beat per input beat, in order, carrying the three filtered
// banks, any_pressed, the current phase code and the response accepted flag.
// The result is registered; throughput is one item per cycle while the skid entry is
// free. All decode, bit mapping and the three-slot AND sit between the input
// handshake and the result register, with sample, bank and phase registers updated
// in the same edge.
// A two-entry result buffer (output register plus skid) lets the block take a beat
// while a result waits; in_ready drops only when both entries are full, so a stall
// on the output side backs up to the input after two held results.
// cfg_wr_en writes the channel select at any edge outside reset; change it only while idle.
// Reset (rst, synchronous) clears samples, banks, slot index, phase, the channel
// select and the valid flags of both result entries.
`default_nettype none

`include "scanned_button_bank_filter_assert.svh"

module scanned_button_bank_filter
  import sbbf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_wr_en,
  input  wire logic       cfg_wr_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] op,
  input  wire logic [7:0] encoded_byte,
  input  wire logic       ready_flag,
  input  wire logic       length_ok,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      bank_zero,
  output logic [7:0]      bank_one,
  output logic [7:0]      bank_two,
  output logic            any_pressed,
  output logic [3:0]      phase_code,
  output logic            accepted
);

  logic       secondary;
  bank_row_t  store [NUM_SLOTS];
  bank_row_t  store_next [NUM_SLOTS];
  bank_row_t  filt;
  bank_row_t  filt_next;
  logic [1:0] slot;
  logic [1:0] slot_next;
  logic [3:0] phase;
  logic [3:0] phase_next;

  result_t    res_out;
  result_t    res_skid;
  result_t    res_new;
  logic       skid_valid;

  logic       in_fire;
  logic       out_fire;
  logic       resp_ok;
  logic [2:0] want_mark;
  bank_row_t  cur_row;
  bank_row_t  new_row;
  bank_row_t  and_row;

  assign in_ready = !skid_valid;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  assign want_mark = secondary ? MARK_SECONDARY : MARK_PRIMARY;
  assign resp_ok   = (op == OP_RESP) && length_ok && ready_flag &&
                     (encoded_byte[7:5] == want_mark);

  always_comb begin
    cur_row = store[0];
    for (int k = 0; k < NUM_SLOTS; k++) begin
      if (slot == 2'(k)) begin
        cur_row = store[k];
      end
    end
    new_row = map_sample(cur_row, phase, encoded_byte[4:0], secondary);
    // AND across slots, with the slot being written taking its new value
    and_row = '1;
    for (int k = 0; k < NUM_SLOTS; k++) begin
      and_row = and_row & ((slot == 2'(k)) ? new_row : store[k]);
    end
  end

  always_comb begin
    store_next = store;
    filt_next  = filt;
    slot_next  = slot;
    phase_next = phase;
    if (in_fire) begin
      case (op)
        OP_START: begin
          phase_next = (phase >> 1);
          if ((phase >> 1) == PH_IDLE) begin
            phase_next = PH_8;
          end
        end
        OP_RESP: begin
          if (resp_ok) begin
            for (int k = 0; k < NUM_SLOTS; k++) begin
              if (slot == 2'(k)) begin
                store_next[k] = new_row;
              end
            end
            filt_next = and_row;
            slot_next = (slot == 2'(NUM_SLOTS - 1)) ? 2'd0 : slot + 2'd1;
          end
        end
        OP_CLEAR: begin
          for (int k = 0; k < NUM_SLOTS; k++) begin
            store_next[k] = '0;
          end
          filt_next  = '0;
          slot_next  = 2'd0;
          phase_next = PH_IDLE;
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
  end

  always_comb begin
    res_new.banks       = filt_next;
    res_new.any_pressed = |filt_next;
    res_new.phase_code  = phase_next;
    res_new.accepted    = resp_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      secondary <= 1'b0;
      filt      <= '0;
      slot      <= 2'd0;
      phase     <= PH_IDLE;
      for (int k = 0; k < NUM_SLOTS; k++) begin
        store[k] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        secondary <= cfg_wr_data;
      end
      filt  <= filt_next;
      slot  <= slot_next;
      phase <= phase_next;
      store <= store_next;
    end
  end

  // Result buffer: the older result always sits in res_out.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || out_fire) begin
        out_valid  <= skid_valid || in_fire;
        skid_valid <= 1'b0;
      end else if (in_fire) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_fire) begin
      res_out <= skid_valid ? res_skid : res_new;
    end
    if (in_fire && out_valid && !out_fire) begin
      res_skid <= res_new;
    end
  end

  assign bank_zero   = res_out.banks[0];
  assign bank_one    = res_out.banks[1];
  assign bank_two    = res_out.banks[2];
  assign any_pressed = res_out.any_pressed;
  assign phase_code  = res_out.phase_code;
  assign accepted    = res_out.accepted;

  `SBBF_ASSERT(a_slot_range, clk, rst, slot != 2'd3, "slot index out of range")
  `SBBF_ASSERT(a_skid_order, clk, rst, skid_valid |-> out_valid, "skid full with output empty")
  `SBBF_ASSERT(a_filt_and, clk, rst, filt == (store[0] & store[1] & store[2]), "banks not AND of slots")
  `SBBF_ASSERT(a_clear, clk, rst, (in_fire && op == OP_CLEAR) |=> (filt == '0 && slot == 2'd0 && phase == PH_IDLE), "clear missed state")
  `SBBF_ASSERT(a_any, clk, rst, out_valid |-> (any_pressed == ((bank_zero | bank_one | bank_two) != 8'd0)), "any_pressed mismatch")

endmodule

`default_nettype wire
